FILE: src/dosc_pkg.sv
// shared widths, constants and controller/datapath interface types
// for the difference-of-squares counter; no dependencies
package dosc_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int COUNT_WIDTH = 10;
    localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH + 1);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [COUNT_WIDTH-1:0] t_count;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture input beat, d = 1, count = 0
        logic div_start;  // start value / d
        logic step;       // score current d and advance it
        logic out_load;   // copy count into output register
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic div_done;   // quotient and remainder are ready
        logic bound_hit;  // d > value / d, search is over
    } t_dp_status;

endpackage

FILE: src/difference_of_squares_counter.sv
// For each input beat, counts the divisors d with d*d <= value, d dividing value
// and d + value/d even: the number of ways to write value as a difference of two
// squares (zero gives zero, count saturates at 1023). One item is worked at a
// time; every trial divisor, from 1 up to floor(sqrt(value)) + 1, runs one
// division on a shared radix-2 divider. The next beat is accepted while the previous
// result still waits on the output.
// Depends on dosc_pkg, dosc_ctrl, dosc_dp and dosc_div.
module difference_of_squares_counter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  dosc_pkg::t_value i_value,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output dosc_pkg::t_count o_pair_count
);

    dosc_pkg::t_dp_cmd    w_cmd;
    dosc_pkg::t_dp_status w_status;

    dosc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    dosc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_value      (i_value),
        .o_pair_count (o_pair_count)
    );

endmodule

FILE: src/dosc_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on dosc_pkg
module dosc_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  dosc_pkg::t_value i_dividend,
    input  dosc_pkg::t_value i_divisor,
    output logic            o_done,
    output dosc_pkg::t_value o_quot,
    output dosc_pkg::t_value o_rem
);

    logic                           r_busy;
    logic                           r_done;
    logic [dosc_pkg::DIV_CNT_W-1:0] r_cnt;
    dosc_pkg::t_value               r_rem;
    dosc_pkg::t_value               r_quo;

    logic [dosc_pkg::VALUE_WIDTH:0]   w_trial;
    logic [dosc_pkg::VALUE_WIDTH:0]   w_diff;
    logic                             w_ge;

    assign w_trial = {r_rem, r_quo[dosc_pkg::VALUE_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign w_ge    = (w_trial >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= dosc_pkg::DIV_CNT_W'(dosc_pkg::VALUE_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == dosc_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[dosc_pkg::VALUE_WIDTH-1:0]
                          : w_trial[dosc_pkg::VALUE_WIDTH-1:0];
            r_quo <= {r_quo[dosc_pkg::VALUE_WIDTH-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

FILE: src/dosc_dp.sv
// datapath: value, trial divisor, hit counter, output register, divider
// depends on dosc_pkg and dosc_div
module dosc_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dosc_pkg::t_dp_cmd    i_cmd,
    output dosc_pkg::t_dp_status o_status,
    input  dosc_pkg::t_value     i_value,
    output dosc_pkg::t_count     o_pair_count
);

    dosc_pkg::t_value r_value;
    dosc_pkg::t_value r_d;
    dosc_pkg::t_count r_count;
    dosc_pkg::t_count r_pair_count;

    logic             w_div_done;
    dosc_pkg::t_value w_quot;
    dosc_pkg::t_value w_rem;
    logic             w_hit;

    dosc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_value),
        .i_divisor  (r_d),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // exact divisor and d + value/d even
    assign w_hit = (w_rem == '0) && (r_d[0] == w_quot[0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
            r_d     <= dosc_pkg::VALUE_WIDTH'(1);
            r_count <= '0;
        end else if (i_cmd.step) begin
            r_d <= r_d + 1'b1;
            if (w_hit && (r_count != dosc_pkg::COUNT_MAX)) begin
                r_count <= r_count + 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_pair_count <= r_count;
        end
    end

    assign o_status.div_done  = w_div_done;
    assign o_status.bound_hit = (r_d > w_quot);
    assign o_pair_count       = r_pair_count;

endmodule

FILE: src/dosc_ctrl.sv
// controller: sequences the trial divisions and runs both handshakes
// depends on dosc_pkg
module dosc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dosc_pkg::t_dp_cmd    o_cmd,
    input  dosc_pkg::t_dp_status i_status
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_START  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_EVAL   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state         = r_state;
        o_cmd.load      = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.step      = 1'b0;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_START;
                end
            end
            ST_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_status.bound_hit) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_START;
                end
            end
            ST_FINISH: begin
                // hold the result until the output register frees up
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while a beat waits");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_bound_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL && i_status.bound_hit) |=> (r_state == ST_FINISH))
        else $error("search did not end at the bound");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_START))
        else $error("accepted beat did not start a search");
`endif

endmodule

FILE: test/difference_of_squares_counter_tb.sv
// self-checking bench for difference_of_squares_counter: drives values over valid/ready,
// predicts each pair_count with an in-bench divisor search and checks results in order
// depends on dosc_pkg and the difference_of_squares_counter rtl
module difference_of_squares_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 6_000_000;
    localparam int REPORT_LIMIT   = 10;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        dosc_pkg::t_value value;
        dosc_pkg::t_count count;
    } t_pending;

    class pair_count_board;
        t_pending         pending_q[$];
        int               accepted;
        int               checked;
        int               fails;
        dosc_pkg::t_value largest = '0;

        // walk d upward while d*d <= v, counting divisors whose cofactor has the same parity
        function dosc_pkg::t_count same_parity_pairs(dosc_pkg::t_value v);
            longint unsigned n;
            longint unsigned d;
            longint unsigned cofactor;
            int unsigned     hits;
            n    = 64'(v);
            hits = 0;
            for (d = 1; d <= n / d; d++) begin
                if (n % d == 0) begin
                    cofactor = n / d;
                    if ((d + cofactor) % 2 == 0) hits++;
                end
            end
            if (hits > 32'(dosc_pkg::COUNT_MAX)) hits = 32'(dosc_pkg::COUNT_MAX);
            return dosc_pkg::t_count'(hits);
        endfunction

        function void note_value(dosc_pkg::t_value v);
            t_pending p;
            p.value = v;
            p.count = same_parity_pairs(v);
            pending_q.push_back(p);
            accepted++;
            if (v > largest) largest = v;
        endfunction

        function void check_count(dosc_pkg::t_count got);
            t_pending p;
            if (pending_q.size() == 0) begin
                fails++;
                if (fails <= REPORT_LIMIT)
                    $display("unexpected result beat: pair_count %0d", got);
                return;
            end
            p = pending_q.pop_front();
            checked++;
            if (got !== p.count) begin
                fails++;
                if (fails <= REPORT_LIMIT)
                    $display("pair_count mismatch: value 0x%08h expected %0d got %0d",
                             p.value, p.count, got);
            end
        endfunction
    endclass

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_in_valid   = 1'b0;
    logic             o_in_ready;
    dosc_pkg::t_value i_value      = '0;
    logic             o_out_valid;
    logic             i_out_ready  = 1'b0;
    dosc_pkg::t_count o_pair_count;

    pair_count_board board;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;

    difference_of_squares_counter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pair_count (o_pair_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // handshake monitor and watchdog, sampling values present at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) board.note_value(i_value);
            if (o_out_valid && i_out_ready) board.check_count(o_pair_count);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, board.pending_q.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_value(input dosc_pkg::t_value v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // sender holds off until every expected count has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending_q.size() != 0);
    endtask

    task automatic run_random_phase(input int count);
        int               sel;
        int unsigned      w;
        int unsigned      k;
        dosc_pkg::t_value v;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                w = $urandom_range(1, 16);
                v = dosc_pkg::t_value'($urandom & ((32'd1 << w) - 1));
            end else if (sel < 70) begin
                // perfect squares put the last trial divisor right on the bound
                k = $urandom_range(1, 300);
                v = dosc_pkg::t_value'(k * k);
            end else if (sel < 80) begin
                v = dosc_pkg::t_value'(($urandom_range(0, 255) | 1) << $urandom_range(0, 14));
            end else if (sel < 90) begin
                // 2 mod 4 never splits into a same-parity pair
                v = dosc_pkg::t_value'(4 * $urandom_range(0, 16383) + 2);
            end else begin
                w = $urandom_range(17, 22);
                v = dosc_pkg::t_value'($urandom & ((32'd1 << w) - 1));
            end
            send_value(v);
        end
    endtask

    initial begin
        dosc_pkg::t_value directed[$];
        board = new();
        directed = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd8, 31'd9,
                     31'd12, 31'd15, 31'd16, 31'd36, 31'd45, 31'd97, 31'd100, 31'd105,
                     31'd720720, 31'd1048576, 31'd2147395600, 31'h7fff_ffff};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 38;
        recv_idle_pct = 68;
        foreach (directed[i]) send_value(directed[i]);
        wait_drained();
        run_random_phase(27);
        wait_drained();

        send_idle_pct = 68;
        recv_idle_pct = 38;
        run_random_phase(26);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(26);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d values sent (directed extremes plus random), largest 0x%08h",
                 board.accepted, board.largest);
        $display("%0d counts checked over three idling mixes, %0d failures",
                 board.checked, board.fails);
        if (board.fails == 0 && board.pending_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: difference_of_squares_counter.f
src/dosc_pkg.sv
src/dosc_div.sv
src/dosc_dp.sv
src/dosc_ctrl.sv
src/difference_of_squares_counter.sv
test/difference_of_squares_counter_tb.sv
